>>> rtl/lrs_pkg.sv
// Shared types, constants and helper functions for the lattice rejection sampler.
// No dependencies; imported by lrs_sampler, lrs_out_queue and the top level.
`default_nettype none

package lrs_pkg;

	// Coefficients per polynomial and width of the coefficient counter
	localparam int NUM_COEFFS = 256;
	localparam int CNT_W      = $clog2(NUM_COEFFS + 1);

	// Result queue
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	// Field widths
	localparam int BYTE_W  = 8;
	localparam int COEF_W  = 24;
	localparam int INDEX_W = 8;
	localparam int MOD_W   = 23;
	localparam int MODE_W  = 2;

	localparam logic [MOD_W-1:0] MODULUS_RESET = 23'd8380417;

	// Sampling modes
	localparam logic [MODE_W-1:0] MODE_UNIFORM = 2'd0;
	localparam logic [MODE_W-1:0] MODE_ETA2    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_ETA4    = 2'd2;

	// Register indexes
	localparam logic REG_MODE    = 1'b0;
	localparam logic REG_MODULUS = 1'b1;

	// Uniform-mode byte phase
	localparam logic [1:0] PHASE_B0 = 2'd0;
	localparam logic [1:0] PHASE_B1 = 2'd1;
	localparam logic [1:0] PHASE_B2 = 2'd2;

	typedef struct packed {
		logic signed [COEF_W-1:0] coefficient;
		logic [INDEX_W-1:0]       coeff_index;
		logic                     last_of_byte;
		logic                     poly_done;
	} result_t;

	// Up to two results written into the queue in one cycle
	typedef struct packed {
		logic [1:0] n;
		result_t    e0;
		result_t    e1;
	} push_t;

	typedef struct packed {
		logic [1:0]       phase;
		logic [CNT_W-1:0] count;
	} samp_stat_t;

	// Nibble accepted in the given eta mode
	function automatic logic eta_ok(input logic [3:0] nib, input logic [MODE_W-1:0] mode);
		logic ok;
		ok = 1'b0;
		if (mode == MODE_ETA2)
			ok = (nib < 4'd15);
		else if (mode == MODE_ETA4)
			ok = (nib < 4'd9);
		return ok;
	endfunction

	// Coefficient for an accepted nibble: 2 - (nib mod 5) or 4 - nib
	function automatic logic signed [COEF_W-1:0] eta_value(input logic [3:0] nib,
			input logic [MODE_W-1:0] mode);
		logic [3:0]        r;
		logic signed [4:0] v;
		if (nib >= 4'd10)
			r = nib - 4'd10;
		else if (nib >= 4'd5)
			r = nib - 4'd5;
		else
			r = nib;
		if (mode == MODE_ETA2)
			v = 5'sd2 - $signed({1'b0, r});
		else
			v = 5'sd4 - $signed({1'b0, nib});
		return COEF_W'(v);
	endfunction

endpackage

`default_nettype wire

>>> rtl/lattice_rejection_sampler_unit.sv
// Lattice rejection sampler: random bytes in, polynomial coefficients out.
// An input beat is registered in the input stage, then pushed into the result queue
// whose head drives the outputs. Uniform mode takes one byte per cycle while the
// queue has room for two results; in eta modes one coefficient per cycle leaves it.
// Reset (arst_n, asynchronous): mode uniform, modulus 8380417, count and phase
// cleared, input stage and result queue empty. Needs lrs_pkg.
`default_nettype none

module lattice_rejection_sampler_unit (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// configuration write port
	input  wire logic                              cfg_we,
	input  wire logic                              cfg_index,
	input  wire logic [lrs_pkg::MOD_W-1:0]         cfg_wdata,
	// byte stream
	input  wire logic                              in_valid,
	output logic                                   in_ready,
	input  wire logic [lrs_pkg::BYTE_W-1:0]        data_byte,
	input  wire logic                              first_byte,
	// coefficient stream
	output logic                                   out_valid,
	input  wire logic                              out_ready,
	output logic signed [lrs_pkg::COEF_W-1:0]      coefficient,
	output logic [lrs_pkg::INDEX_W-1:0]            coeff_index,
	output logic                                   last_of_byte,
	output logic                                   poly_done
);
	import lrs_pkg::*;

	// Configuration registers
	logic [MODE_W-1:0] mode_q;
	logic [MOD_W-1:0]  modulus_q;

	// Input stage: one byte held while the queue has no room for two results
	logic              vld_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              first_s1;
	logic              advance;

	push_t             push;
	samp_stat_t        stat;
	result_t           head;
	logic [QCNT_W-1:0] q_count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_UNIFORM;
			modulus_q <= MODULUS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MODE:    mode_q    <= cfg_wdata[MODE_W-1:0];
				REG_MODULUS: modulus_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// A byte leaves the input stage only when the queue can take two results,
	// whatever the byte actually yields; this keeps the check off the datapath.
	assign advance  = vld_s1 && (q_count <= QCNT_W'(QDEPTH - 2));
	assign in_ready = !vld_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s1 <= 1'b0;
		else if (in_ready)
			vld_s1 <= in_valid;
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1  <= data_byte;
			first_s1 <= first_byte;
		end
	end

	lrs_sampler u_sampler (
		.clk      (clk),
		.arst_n   (arst_n),
		.advance  (advance),
		.byte_s1  (byte_s1),
		.first_s1 (first_s1),
		.mode     (mode_q),
		.modulus  (modulus_q),
		.push     (push),
		.stat     (stat)
	);

	lrs_out_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.head      (head),
		.count     (q_count)
	);

	assign coefficient  = head.coefficient;
	assign coeff_index  = head.coeff_index;
	assign last_of_byte = head.last_of_byte;
	assign poly_done    = head.poly_done;

	// Checks

	// a push must never overrun the result queue
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push.n != 2'd0) |-> (q_count <= QCNT_W'(QDEPTH - 2)))
		else $error("result push without room in queue");

	// the coefficient count never runs past a full polynomial
	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		stat.count <= CNT_W'(NUM_COEFFS))
		else $error("coefficient count beyond polynomial size");

	// any byte handled in an eta mode leaves the uniform phase at the start
	a_eta_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && (mode_q == MODE_ETA2 || mode_q == MODE_ETA4)) |=> (stat.phase == PHASE_B0))
		else $error("byte phase not cleared by eta byte");

	// the queue never reports data it cannot hold
	a_q_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= QCNT_W'(QDEPTH))
		else $error("result queue occupancy out of range");

endmodule

`default_nettype wire

>>> rtl/lrs_sampler.sv
// Sampling datapath: byte phase, partial word and coefficient count, plus the
// logic that turns one registered byte into up to two results. Uses lrs_pkg.
`default_nettype none

module lrs_sampler (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        advance,
	input  wire logic [lrs_pkg::BYTE_W-1:0]  byte_s1,
	input  wire logic                        first_s1,
	input  wire logic [lrs_pkg::MODE_W-1:0]  mode,
	input  wire logic [lrs_pkg::MOD_W-1:0]   modulus,
	output lrs_pkg::push_t                   push,
	output lrs_pkg::samp_stat_t              stat
);
	import lrs_pkg::*;

	logic [1:0]       phase_q;
	logic [15:0]      partial_q;
	logic [CNT_W-1:0] count_q;

	logic [1:0]       eff_phase, nxt_phase;
	logic [15:0]      eff_partial, nxt_partial;
	logic [CNT_W-1:0] eff_cnt;
	logic             full;
	logic [MOD_W-1:0] word;
	logic             a_vld, b_vld;
	logic signed [COEF_W-1:0] a_val, b_val;
	logic [CNT_W:0]   cnt_ext;

	// first_byte clears state before the byte is looked at
	assign eff_phase   = first_s1 ? PHASE_B0 : phase_q;
	assign eff_partial = first_s1 ? 16'd0 : partial_q;
	assign eff_cnt     = first_s1 ? '0 : count_q;
	assign full        = (eff_cnt >= CNT_W'(NUM_COEFFS));
	assign word        = {byte_s1[6:0], eff_partial};
	assign cnt_ext     = {1'b0, eff_cnt};

	always_comb begin
		nxt_phase   = eff_phase;
		nxt_partial = eff_partial;
		a_vld       = 1'b0;
		a_val       = '0;
		b_vld       = 1'b0;
		b_val       = '0;
		if (!full) begin
			if (mode == MODE_UNIFORM) begin
				if (eff_phase == PHASE_B0) begin
					nxt_partial = {8'd0, byte_s1};
					nxt_phase   = PHASE_B1;
				end else if (eff_phase == PHASE_B1) begin
					nxt_partial = {byte_s1, eff_partial[7:0]};
					nxt_phase   = PHASE_B2;
				end else begin
					nxt_partial = 16'd0;
					nxt_phase   = PHASE_B0;
					a_vld       = (word < modulus);
					a_val       = COEF_W'({1'b0, word});
				end
			end else if (mode == MODE_ETA2 || mode == MODE_ETA4) begin
				nxt_partial = 16'd0;
				nxt_phase   = PHASE_B0;
				a_vld       = eta_ok(byte_s1[3:0], mode);
				a_val       = eta_value(byte_s1[3:0], mode);
				// high nibble dropped once the low one fills the polynomial
				b_vld       = eta_ok(byte_s1[7:4], mode) &&
					((cnt_ext + (CNT_W+1)'(a_vld)) < (CNT_W+1)'(NUM_COEFFS));
				b_val       = eta_value(byte_s1[7:4], mode);
			end
		end
	end

	// Pack results in order; e0 always takes index eff_cnt, e1 the next one
	always_comb begin
		push.n                  = 2'(a_vld) + 2'(b_vld);
		push.e0.coefficient     = a_vld ? a_val : b_val;
		push.e0.coeff_index     = INDEX_W'(eff_cnt);
		push.e0.last_of_byte    = !(a_vld && b_vld);
		push.e0.poly_done       = ((cnt_ext + 1'b1) == (CNT_W+1)'(NUM_COEFFS));
		push.e1.coefficient     = b_val;
		push.e1.coeff_index     = INDEX_W'(cnt_ext + 1'b1);
		push.e1.last_of_byte    = 1'b1;
		push.e1.poly_done       = ((cnt_ext + (CNT_W+1)'(2)) == (CNT_W+1)'(NUM_COEFFS));
		if (!advance)
			push.n = 2'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PHASE_B0;
			partial_q <= 16'd0;
			count_q   <= '0;
		end else if (advance) begin
			phase_q   <= nxt_phase;
			partial_q <= nxt_partial;
			count_q   <= CNT_W'(cnt_ext + (CNT_W+1)'(a_vld) + (CNT_W+1)'(b_vld));
		end
	end

	assign stat.phase = phase_q;
	assign stat.count = count_q;

endmodule

`default_nettype wire

>>> rtl/lrs_out_queue.sv
// Four-entry result queue: takes up to two results a cycle, hands out one.
// Uses lrs_pkg for the result and push types.
`default_nettype none

module lrs_out_queue (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire lrs_pkg::push_t             push,
	input  wire logic                       out_ready,
	output logic                            out_valid,
	output lrs_pkg::result_t                head,
	output logic [lrs_pkg::QCNT_W-1:0]      count
);
	import lrs_pkg::*;

	result_t           mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q, rd_q;
	logic [QCNT_W-1:0] count_q;
	logic              pop;

	assign out_valid = (count_q != '0);
	assign pop       = out_valid && out_ready;
	assign head      = mem_q[rd_q];
	assign count     = count_q;

	always_ff @(posedge clk) begin
		if (push.n != 2'd0)
			mem_q[wr_q] <= push.e0;
		if (push.n == 2'd2)
			mem_q[wr_q + QPTR_W'(1)] <= push.e1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + QPTR_W'(push.n);
			rd_q    <= rd_q + QPTR_W'(pop);
			count_q <= count_q + QCNT_W'(push.n) - QCNT_W'(pop);
		end
	end

endmodule

`default_nettype wire
